### hw/rtl/tvva_pkg.sv
// Shared types, widths and register codes for the tiled volume voxel address unit.
// No dependencies.
package tvva_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 32;
    localparam int PXL_W      = POS_W - FRAC_BITS;   // integer part of a position
    localparam int PIX_W      = 12;                   // stored pixel minus one
    localparam int PIXIN_W    = 13;
    localparam int SLOT_W     = 16;
    localparam int ENTRY_W    = 2 * PIX_W;
    localparam int MAP_DIM_W  = 9;
    localparam int IMG_W      = 13;
    localparam int GRID_W     = 11;
    localparam int CELL_W     = 2 * MAP_DIM_W;
    localparam int Z_W        = FRAC_BITS + 1;
    localparam int UX_W       = PIX_W + FRAC_BITS;
    localparam int DEN_W      = IMG_W + FRAC_BITS;
    localparam int NUM_W      = UX_W + GRID_W;
    localparam int ZP_W       = Z_W + GRID_W;
    localparam int M1_W       = 2 * GRID_W + 1;
    localparam int IDX_W      = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int DEF_MAP_ENTRIES = 65536;
    localparam int QUEUE_DEPTH     = 8;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH       = 32;
    localparam int OCNT_W          = $clog2(OUT_DEPTH + 1);

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH    = 3'd0,
        REG_MAP_HEIGHT   = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_GRID_X       = 3'd4,
        REG_GRID_Y       = 3'd5,
        REG_GRID_Z       = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [MAP_DIM_W-1:0] map_w;
        logic [MAP_DIM_W-1:0] map_h;
        logic [IMG_W-1:0]     img_w;
        logic [IMG_W-1:0]     img_h;
        logic [GRID_W-1:0]    grid_x;
        logic [GRID_W-1:0]    grid_y;
        logic [GRID_W-1:0]    grid_z;
    } cfg_t;

    typedef struct packed {
        logic                 miss;
        logic [ENTRY_W-1:0]   entry;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [Z_W-1:0]       z;
    } lookup_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] voxel_index;
    } result_t;

endpackage

### hw/rtl/tvva_fifo.sv
// Small register FIFO used between the front and back parts and at the output.
// No package dependencies.
module tvva_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

endmodule

### hw/rtl/tvva_front.sv
// Front part: accepts items, applies map writes, classifies lookups and reads the map.
// Depends on tvva_pkg.
module tvva_front #(
    parameter int MAP_ENTRIES = tvva_pkg::DEF_MAP_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [tvva_pkg::SLOT_W-1:0]     entry_slot,
    input  logic [tvva_pkg::PIXIN_W-1:0]    pixel_col,
    input  logic [tvva_pkg::PIXIN_W-1:0]    pixel_row,
    input  logic [tvva_pkg::POS_W-1:0]      pos_x,
    input  logic [tvva_pkg::POS_W-1:0]      pos_y,
    input  logic [tvva_pkg::POS_W-1:0]      pos_z,
    input  tvva_pkg::cfg_t                  cfg,
    input  logic [tvva_pkg::QCNT_W-1:0]     q_count,
    output logic                            push,
    output tvva_pkg::lookup_t               push_item
);
    localparam int AW    = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int F     = tvva_pkg::FRAC_BITS;
    localparam int PW    = tvva_pkg::POS_W;
    localparam int SUM_W = tvva_pkg::QCNT_W + 1;

    logic accept;

    // Stage 1: accepted item
    logic                          f1_valid_reg;
    logic                          f1_func_reg;
    logic [tvva_pkg::SLOT_W-1:0]   f1_slot_reg;
    logic [tvva_pkg::PIX_W-1:0]    f1_col0_reg, f1_row0_reg;
    logic [PW-1:0]                 f1_x_reg, f1_y_reg, f1_z_reg;

    // Stage 2: memory access
    logic                          f2_valid_reg;
    logic                          f2_we_reg;
    logic [AW-1:0]                 f2_addr_reg;
    logic [tvva_pkg::ENTRY_W-1:0]  f2_wdata_reg;
    logic                          f2_miss_reg;
    logic [F-1:0]                  f2_fx_reg, f2_fy_reg;
    logic [tvva_pkg::Z_W-1:0]      f2_z_reg;

    // Stage 3: entry read back
    logic                          f3_valid_reg;
    logic                          f3_miss_reg;
    logic [F-1:0]                  f3_fx_reg, f3_fy_reg;
    logic [tvva_pkg::Z_W-1:0]      f3_z_reg;
    logic [tvva_pkg::ENTRY_W-1:0]  rd_data_reg;

    logic [tvva_pkg::ENTRY_W-1:0]  map_mem [MAP_ENTRIES];

    logic [tvva_pkg::PXL_W-1:0]    px, py;
    logic                          out_x, out_y, z_bad, cell_oob, slot_ok;
    logic [tvva_pkg::CELL_W-1:0]   cell_idx;
    logic [SUM_W-1:0]              pending;

    // Reserve queue room for every item still in the front pipeline.
    assign pending  = SUM_W'(q_count) + SUM_W'(f1_valid_reg) + SUM_W'(f2_valid_reg)
                    + SUM_W'(f3_valid_reg);
    assign in_ready = (pending < SUM_W'(tvva_pkg::QUEUE_DEPTH - 1));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        px    = f1_x_reg[PW-1:F];
        py    = f1_y_reg[PW-1:F];
        out_x = f1_x_reg[PW-1] || (px >= tvva_pkg::PXL_W'(cfg.map_w));
        out_y = f1_y_reg[PW-1] || (py >= tvva_pkg::PXL_W'(cfg.map_h));
        z_bad = f1_z_reg[PW-1] || (f1_z_reg > PW'(1 << F));
        cell_idx = tvva_pkg::CELL_W'({9'd0, py[tvva_pkg::MAP_DIM_W-1:0]}
                   * {9'd0, cfg.map_w}) + tvva_pkg::CELL_W'(px[tvva_pkg::MAP_DIM_W-1:0]);
        cell_oob = (32'(cell_idx) >= 32'(MAP_ENTRIES));
        slot_ok  = (32'(f1_slot_reg) < 32'(MAP_ENTRIES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f2_we_reg    <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg && (f1_func_reg == tvva_pkg::FUNC_LOOKUP);
            f2_we_reg    <= f1_valid_reg && (f1_func_reg == tvva_pkg::FUNC_WRITE) && slot_ok;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_func_reg <= func;
            f1_slot_reg <= entry_slot;
            f1_col0_reg <= tvva_pkg::PIX_W'(pixel_col - 1'b1);
            f1_row0_reg <= tvva_pkg::PIX_W'(pixel_row - 1'b1);
            f1_x_reg    <= pos_x;
            f1_y_reg    <= pos_y;
            f1_z_reg    <= pos_z;
        end
        f2_addr_reg  <= (f1_func_reg == tvva_pkg::FUNC_LOOKUP) ? AW'(cell_idx)
                                                                : AW'(f1_slot_reg);
        f2_wdata_reg <= {f1_row0_reg, f1_col0_reg};
        f2_miss_reg  <= out_x || out_y || z_bad || cell_oob;
        f2_fx_reg    <= f1_x_reg[F-1:0];
        f2_fy_reg    <= f1_y_reg[F-1:0];
        f2_z_reg     <= f1_z_reg[tvva_pkg::Z_W-1:0];
        f3_miss_reg  <= f2_miss_reg;
        f3_fx_reg    <= f2_fx_reg;
        f3_fy_reg    <= f2_fy_reg;
        f3_z_reg     <= f2_z_reg;
    end

    // Map table: writes and reads leave stage 2 in item order.
    always_ff @(posedge clk)
    begin
        if (f2_we_reg)
        begin
            map_mem[f2_addr_reg] <= f2_wdata_reg;
        end
        if (f2_valid_reg)
        begin
            rd_data_reg <= map_mem[f2_addr_reg];
        end
    end

    assign push            = f3_valid_reg;
    assign push_item.miss  = f3_miss_reg;
    assign push_item.entry = rd_data_reg;
    assign push_item.fx    = f3_fx_reg;
    assign push_item.fy    = f3_fy_reg;
    assign push_item.z     = f3_z_reg;

endmodule

### hw/rtl/tvva_back.sv
// Back part: scales, divides bit by bit, clamps and linearizes each lookup.
// Depends on tvva_pkg.
module tvva_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  tvva_pkg::lookup_t           q_item,
    output logic                        q_pop,
    input  tvva_pkg::cfg_t              cfg,
    input  logic [tvva_pkg::OCNT_W-1:0] o_count,
    output logic                        push,
    output tvva_pkg::result_t           push_item
);
    localparam int F     = tvva_pkg::FRAC_BITS;
    localparam int GW    = tvva_pkg::GRID_W;
    localparam int NW    = tvva_pkg::NUM_W;
    localparam int NDIV  = GW;
    localparam int CNT_W = tvva_pkg::OCNT_W + 1;

    logic [GW-1:0]                gx1, gy1, gz1;
    logic [tvva_pkg::IMG_W-1:0]   iw1, ih1;
    logic [tvva_pkg::DEN_W-1:0]   denx, deny;

    assign gx1  = (cfg.grid_x == '0) ? GW'(1) : cfg.grid_x;
    assign gy1  = (cfg.grid_y == '0) ? GW'(1) : cfg.grid_y;
    assign gz1  = (cfg.grid_z == '0) ? GW'(1) : cfg.grid_z;
    assign iw1  = (cfg.img_w == '0) ? tvva_pkg::IMG_W'(1) : cfg.img_w;
    assign ih1  = (cfg.img_h == '0) ? tvva_pkg::IMG_W'(1) : cfg.img_h;
    assign denx = {iw1, {F{1'b0}}};
    assign deny = {ih1, {F{1'b0}}};

    logic [CNT_W-1:0] inflight_reg, inflight_next;

    assign q_pop = q_valid
        && ((CNT_W'(o_count) + inflight_reg) < CNT_W'(tvva_pkg::OUT_DEPTH));

    always_comb
    begin
        inflight_next = inflight_reg;
        if (q_pop && !push)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (push && !q_pop)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    // Stage b1: popped item
    logic                        b1_valid_reg, b1_miss_reg;
    logic [tvva_pkg::UX_W-1:0]   b1_ux_reg, b1_uy_reg;
    logic [tvva_pkg::Z_W-1:0]    b1_z_reg;

    // Stage b2: products
    logic                        b2_valid_reg, b2_miss_reg, b2_clx_reg, b2_cly_reg;
    logic [NW-1:0]               b2_nx_reg, b2_ny_reg;
    logic [tvva_pkg::ZP_W-1:0]   b2_zp_reg;
    logic [tvva_pkg::ZP_W-F-1:0] iz_raw;
    logic [GW-1:0]               b2_iz;

    // Divider stages
    logic          dv_valid_reg [NDIV];
    logic          dv_miss_reg  [NDIV];
    logic          dv_clx_reg   [NDIV];
    logic          dv_cly_reg   [NDIV];
    logic [NW-1:0] dv_rx_reg    [NDIV];
    logic [NW-1:0] dv_ry_reg    [NDIV];
    logic [GW-1:0] dv_qx_reg    [NDIV];
    logic [GW-1:0] dv_qy_reg    [NDIV];
    logic [GW-1:0] dv_iz_reg    [NDIV];

    // Linearize stages
    logic                        l1_valid_reg, l1_miss_reg;
    logic [tvva_pkg::M1_W-1:0]   l1_m1_reg;
    logic [GW-1:0]               l1_ix_reg;
    logic                        l2_valid_reg, l2_hit_reg;
    logic [tvva_pkg::IDX_W-1:0]  l2_idx_reg;
    logic [GW-1:0]               ix, iy;

    assign iz_raw = b2_zp_reg[tvva_pkg::ZP_W-1:F];
    assign b2_iz  = (iz_raw >= (tvva_pkg::ZP_W-F)'(gz1)) ? gz1 - 1'b1 : GW'(iz_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            l1_valid_reg <= 1'b0;
            l2_valid_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            b1_valid_reg <= q_pop;
            b2_valid_reg <= b1_valid_reg;
            l1_valid_reg <= dv_valid_reg[NDIV-1];
            l2_valid_reg <= l1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_miss_reg <= q_item.miss;
        b1_ux_reg   <= {q_item.entry[tvva_pkg::PIX_W-1:0], q_item.fx};
        b1_uy_reg   <= {q_item.entry[tvva_pkg::ENTRY_W-1:tvva_pkg::PIX_W], q_item.fy};
        b1_z_reg    <= q_item.z;

        b2_miss_reg <= b1_miss_reg;
        b2_nx_reg   <= NW'(b1_ux_reg) * NW'(gx1);
        b2_ny_reg   <= NW'(b1_uy_reg) * NW'(gy1);
        // a cell value at or past the image edge would give a quotient >= grid
        b2_clx_reg  <= (tvva_pkg::DEN_W'(b1_ux_reg) >= denx);
        b2_cly_reg  <= (tvva_pkg::DEN_W'(b1_uy_reg) >= deny);
        b2_zp_reg   <= tvva_pkg::ZP_W'(b1_z_reg) * tvva_pkg::ZP_W'(gz1);
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        logic          in_valid, in_miss, in_clx, in_cly;
        logic [NW-1:0] in_rx, in_ry, dsx, dsy;
        logic [GW-1:0] in_qx, in_qy, in_iz;

        if (j == 0)
        begin : g_first
            assign in_valid = b2_valid_reg;
            assign in_miss  = b2_miss_reg;
            assign in_clx   = b2_clx_reg;
            assign in_cly   = b2_cly_reg;
            assign in_rx    = b2_nx_reg;
            assign in_ry    = b2_ny_reg;
            assign in_qx    = '0;
            assign in_qy    = '0;
            assign in_iz    = b2_iz;
        end
        else
        begin : g_next
            assign in_valid = dv_valid_reg[j-1];
            assign in_miss  = dv_miss_reg[j-1];
            assign in_clx   = dv_clx_reg[j-1];
            assign in_cly   = dv_cly_reg[j-1];
            assign in_rx    = dv_rx_reg[j-1];
            assign in_ry    = dv_ry_reg[j-1];
            assign in_qx    = dv_qx_reg[j-1];
            assign in_qy    = dv_qy_reg[j-1];
            assign in_iz    = dv_iz_reg[j-1];
        end

        assign dsx = NW'(denx) << (NDIV - 1 - j);
        assign dsy = NW'(deny) << (NDIV - 1 - j);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[j] <= in_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_miss_reg[j] <= in_miss;
            dv_clx_reg[j]  <= in_clx;
            dv_cly_reg[j]  <= in_cly;
            dv_iz_reg[j]   <= in_iz;
            if (in_rx >= dsx)
            begin
                dv_rx_reg[j] <= in_rx - dsx;
                dv_qx_reg[j] <= {in_qx[GW-2:0], 1'b1};
            end
            else
            begin
                dv_rx_reg[j] <= in_rx;
                dv_qx_reg[j] <= {in_qx[GW-2:0], 1'b0};
            end
            if (in_ry >= dsy)
            begin
                dv_ry_reg[j] <= in_ry - dsy;
                dv_qy_reg[j] <= {in_qy[GW-2:0], 1'b1};
            end
            else
            begin
                dv_ry_reg[j] <= in_ry;
                dv_qy_reg[j] <= {in_qy[GW-2:0], 1'b0};
            end
        end
    end

    assign ix = dv_clx_reg[NDIV-1] ? gx1 - 1'b1 : dv_qx_reg[NDIV-1];
    assign iy = dv_cly_reg[NDIV-1] ? gy1 - 1'b1 : dv_qy_reg[NDIV-1];

    always_ff @(posedge clk)
    begin
        l1_miss_reg <= dv_miss_reg[NDIV-1];
        l1_m1_reg   <= tvva_pkg::M1_W'(dv_iz_reg[NDIV-1]) * tvva_pkg::M1_W'(gy1)
                     + tvva_pkg::M1_W'(iy);
        l1_ix_reg   <= ix;
        l2_hit_reg  <= !l1_miss_reg;
        l2_idx_reg  <= l1_miss_reg ? '0
                     : tvva_pkg::IDX_W'(34'(l1_m1_reg) * 34'(gx1) + 34'(l1_ix_reg));
    end

    assign push                  = l2_valid_reg;
    assign push_item.hit         = l2_hit_reg;
    assign push_item.voxel_index = l2_idx_reg;

endmodule

### hw/rtl/tiled_volume_voxel_address_unit.sv
// Top level of the tiled volume voxel address unit: configuration registers,
// front part, lookup queue, back part and result queue. Depends on tvva_pkg,
// tvva_front, tvva_fifo and tvva_back.
//
// Usage:
//  - s_axis carries items. tuser[0] = func (0 map write, 1 lookup). tdata holds
//    entry_slot, pixel_col, pixel_row, pos_x, pos_y, pos_z from bit 0 up.
//  - A map write produces no result; a lookup produces exactly one m_axis item
//    with tuser[0] = hit and tdata[29:0] = voxel_index (0 on a miss).
//  - cfg_we/cfg_index/cfg_data write the seven size registers while the unit
//    is idle; all reset to 1.
// Timing:
//  - One item per cycle is accepted while the queues have room; a write is
//    visible to a lookup accepted in the next cycle.
//  - On the lookup path from acceptance to m_axis_tvalid lie three front
//    stages (decode, map access, entry read), the lookup queue, 15 back
//    stages, eleven of them a one-bit-per-stage divider per axis, and the result queue.
//  - When m_axis_tready drops, results collect in a 32-entry queue; the back
//    part stops pulling from the lookup queue, and s_axis_tready falls once
//    the 8-entry lookup queue has no room left for items in flight.
// Reset: all queues empty, pipelines idle; the map table keeps its contents
// and is undefined until written.
module tiled_volume_voxel_address_unit #(
    parameter int MAP_ENTRIES = tvva_pkg::DEF_MAP_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_slot[15:0], pixel_col[28:16], pixel_row[41:29], pos_x[73:42],
    // pos_y[105:74], pos_z[137:106], zero fill above
    input  logic [143:0]                        s_axis_tdata,
    // func[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // voxel_index[29:0], zero fill above
    output logic [31:0]                         m_axis_tdata,
    // hit[0]
    output logic [0:0]                          m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [tvva_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tvva_pkg::CFG_DATA_W-1:0]     cfg_data
);
    tvva_pkg::cfg_t cfg_reg, cfg_next;

    // Decode a register write; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (tvva_pkg::cfg_index_t'(cfg_index))
                tvva_pkg::REG_MAP_WIDTH:    cfg_next.map_w  = cfg_data[8:0];
                tvva_pkg::REG_MAP_HEIGHT:   cfg_next.map_h  = cfg_data[8:0];
                tvva_pkg::REG_IMAGE_WIDTH:  cfg_next.img_w  = cfg_data;
                tvva_pkg::REG_IMAGE_HEIGHT: cfg_next.img_h  = cfg_data;
                tvva_pkg::REG_GRID_X:       cfg_next.grid_x = cfg_data[10:0];
                tvva_pkg::REG_GRID_Y:       cfg_next.grid_y = cfg_data[10:0];
                tvva_pkg::REG_GRID_Z:       cfg_next.grid_z = cfg_data[10:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_w  <= 9'd1;
            cfg_reg.map_h  <= 9'd1;
            cfg_reg.img_w  <= 13'd1;
            cfg_reg.img_h  <= 13'd1;
            cfg_reg.grid_x <= 11'd1;
            cfg_reg.grid_y <= 11'd1;
            cfg_reg.grid_z <= 11'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    logic                            lq_push, lq_pop, lq_valid;
    tvva_pkg::lookup_t               lq_in, lq_out;
    logic [tvva_pkg::QCNT_W-1:0]     lq_count;
    logic                            oq_push, oq_pop, oq_valid;
    tvva_pkg::result_t               oq_in, oq_out;
    logic [tvva_pkg::OCNT_W-1:0]     oq_count;

    tvva_front #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .func       (s_axis_tuser[0]),
        .entry_slot (s_axis_tdata[15:0]),
        .pixel_col  (s_axis_tdata[28:16]),
        .pixel_row  (s_axis_tdata[41:29]),
        .pos_x      (s_axis_tdata[73:42]),
        .pos_y      (s_axis_tdata[105:74]),
        .pos_z      (s_axis_tdata[137:106]),
        .cfg        (cfg_reg),
        .q_count    (lq_count),
        .push       (lq_push),
        .push_item  (lq_in)
    );

    tvva_fifo #(
        .WIDTH ($bits(tvva_pkg::lookup_t)),
        .DEPTH (tvva_pkg::QUEUE_DEPTH)
    ) u_lookup_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (lq_push),
        .push_data (lq_in),
        .pop       (lq_pop),
        .pop_data  (lq_out),
        .not_empty (lq_valid),
        .count     (lq_count)
    );

    tvva_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (lq_valid),
        .q_item    (lq_out),
        .q_pop     (lq_pop),
        .cfg       (cfg_reg),
        .o_count   (oq_count),
        .push      (oq_push),
        .push_item (oq_in)
    );

    tvva_fifo #(
        .WIDTH ($bits(tvva_pkg::result_t)),
        .DEPTH (tvva_pkg::OUT_DEPTH)
    ) u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (oq_push),
        .push_data (oq_in),
        .pop       (oq_pop),
        .pop_data  (oq_out),
        .not_empty (oq_valid),
        .count     (oq_count)
    );

    // Drive results straight from the head of the result queue.
    assign m_axis_tvalid   = oq_valid;
    assign oq_pop          = oq_valid && m_axis_tready;
    assign m_axis_tdata    = {2'b00, oq_out.voxel_index};
    assign m_axis_tuser[0] = oq_out.hit;

    // Credits must keep both queues from overflowing.
    a_lq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lq_count <= tvva_pkg::QCNT_W'(tvva_pkg::QUEUE_DEPTH))
        else $error("lookup queue overflow");

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !(oq_push && !oq_pop && oq_count == tvva_pkg::OCNT_W'(tvva_pkg::OUT_DEPTH)))
        else $error("result queue overflow");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("miss result with nonzero index");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        lq_pop |-> lq_valid)
        else $error("lookup queue popped while empty");

endmodule

### tb/tb_top.sv
// Testbench for tiled_volume_voxel_address_unit: directed table, then random map writes
// and lookups over several register settings, checked against an in-bench voxel predictor.
// Depends on tvva_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;   // leave margin over the lookup latency
    localparam int PHASE_ITEMS    = 140;
    localparam int FB             = tvva_pkg::FRAC_BITS;

    typedef struct {
        logic        func;
        logic [15:0] slot;
        logic [12:0] col;
        logic [12:0] row;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          typed;     // expected result given in the row
        bit          hit;
        logic [29:0] idx;
    } stim_row_t;

    typedef struct {
        bit          hit;
        logic [29:0] idx;
    } voxel_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         cfg_we = 1'b0;
    logic [tvva_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tvva_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    tiled_volume_voxel_address_unit dut (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the unit: map table, written flags and size registers
    logic [23:0]  map_shadow [65536];
    bit           slot_written [65536];
    int unsigned  written_slots [$];
    int unsigned  map_w = 1, map_h = 1, img_w = 1, img_h = 1;
    int unsigned  gx = 1, gy = 1, gz = 1;

    voxel_t       pending_voxels [$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           writes_sent = 0, lookups_sent = 0, hits_seen = 0, configs_run = 0;

    function automatic longint unsigned one_if_zero(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic longint unsigned scale_axis(longint unsigned pix0,
                                                   longint unsigned frac,
                                                   int unsigned img, int unsigned grid);
        longint unsigned g, u, q;
        g = one_if_zero(grid);
        u = (pix0 << FB) + frac;
        q = (u * g) / (one_if_zero(img) << FB);
        return (q > g - 1) ? g - 1 : q;
    endfunction

    function automatic voxel_t predict_voxel(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        voxel_t          v;
        longint          sx, sy, sz, px, py;
        longint unsigned cell_idx, ix, iy, iz, g3, raw;
        v.hit = 1'b0;
        v.idx = '0;
        sx = longint'($signed(x));
        sy = longint'($signed(y));
        sz = longint'($signed(z));
        px = sx >>> FB;
        py = sy >>> FB;
        if (px < 0 || px >= map_w || py < 0 || py >= map_h || sz < 0 || sz > 65536)
            return v;
        cell_idx = longint'(py) * map_w + longint'(px);
        if (cell_idx >= 65536)
            return v;
        ix = scale_axis(map_shadow[cell_idx][11:0], x[15:0], img_w, gx);
        iy = scale_axis(map_shadow[cell_idx][23:12], y[15:0], img_h, gy);
        g3 = one_if_zero(gz);
        iz = (longint'(sz) * g3) >> FB;
        if (iz > g3 - 1)
            iz = g3 - 1;
        raw = (iz * one_if_zero(gy) + iy) * one_if_zero(gx) + ix;
        v.hit = 1'b1;
        v.idx = raw[29:0];
        return v;
    endfunction

    // True when a lookup at (x, y) would read a map entry never written
    function automatic bit reads_unwritten(logic [31:0] x, logic [31:0] y);
        longint px, py, cell_idx;
        px = longint'($signed(x)) >>> FB;
        py = longint'($signed(y)) >>> FB;
        if (px < 0 || px >= map_w || py < 0 || py >= map_h)
            return 1'b0;
        cell_idx = py * map_w + px;
        return cell_idx < 65536 && !slot_written[cell_idx];
    endfunction

    task automatic write_reg(tvva_pkg::cfg_index_t idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[tvva_pkg::CFG_DATA_W-1:0];
        case (idx)
            tvva_pkg::REG_MAP_WIDTH:    map_w = val & 'h1FF;
            tvva_pkg::REG_MAP_HEIGHT:   map_h = val & 'h1FF;
            tvva_pkg::REG_IMAGE_WIDTH:  img_w = val & 'h1FFF;
            tvva_pkg::REG_IMAGE_HEIGHT: img_h = val & 'h1FFF;
            tvva_pkg::REG_GRID_X:       gx = val & 'h7FF;
            tvva_pkg::REG_GRID_Y:       gy = val & 'h7FF;
            tvva_pkg::REG_GRID_Z:       gz = val & 'h7FF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pending_voxels.size() != 0)
            @(posedge clk);
        // writes give no result; let the pipeline empty anyway
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(int unsigned mw, int unsigned mh, int unsigned iw,
                               int unsigned ih, int unsigned x, int unsigned y,
                               int unsigned z);
        wait_idle();
        write_reg(tvva_pkg::REG_MAP_WIDTH, mw);
        write_reg(tvva_pkg::REG_MAP_HEIGHT, mh);
        write_reg(tvva_pkg::REG_IMAGE_WIDTH, iw);
        write_reg(tvva_pkg::REG_IMAGE_HEIGHT, ih);
        write_reg(tvva_pkg::REG_GRID_X, x);
        write_reg(tvva_pkg::REG_GRID_Y, y);
        write_reg(tvva_pkg::REG_GRID_Z, z);
        cfg_we <= 1'b0;
        configs_run++;
    endtask

    // Present one item, hold it until accepted, then update the shadow
    task automatic send_item(stim_row_t r);
        // idle the sender at the phase's rate, drawing again at every clock
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.func;
        s_axis_tdata  <= {6'b0, r.z, r.y, r.x, r.row, r.col, r.slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (r.func == tvva_pkg::FUNC_WRITE)
        begin
            map_shadow[r.slot] = {r.row[11:0] - 12'd1, r.col[11:0] - 12'd1};
            if (!slot_written[r.slot])
                written_slots.push_back(r.slot);
            slot_written[r.slot] = 1'b1;
            writes_sent++;
        end
        else
        begin
            voxel_t v;
            if (r.typed)
            begin
                v.hit = r.hit;
                v.idx = r.idx;
            end
            else
                v = predict_voxel(r.x, r.y, r.z);
            pending_voxels.push_back(v);
            lookups_sent++;
        end
    endtask

    // Well-formed lookups land on written cells; noise stays off unwritten ones
    function automatic stim_row_t random_item(bit allow_noise);
        stim_row_t   r;
        int unsigned pick, slot;
        r = '{default: '0};
        r.slot = 16'($urandom());
        r.col  = 13'($urandom());
        r.row  = 13'($urandom());
        r.x    = $urandom();
        r.y    = $urandom();
        r.z    = $urandom_range(65536);
        pick   = $urandom_range(99);
        if (pick < 25 || written_slots.size() == 0)
        begin
            r.func = tvva_pkg::FUNC_WRITE;
            if ($urandom_range(1) && map_w * map_h != 0)
                r.slot = 16'($urandom_range(((map_w * map_h > 65536) ? 65536
                                                                      : map_w * map_h) - 1));
            return r;
        end
        r.func = tvva_pkg::FUNC_LOOKUP;
        if (pick < 85 || !allow_noise)
        begin
            slot = written_slots[$urandom_range(written_slots.size() - 1)];
            if (map_w != 0)
            begin
                r.x[31:16] = 16'(slot % map_w);
                r.y[31:16] = 16'(slot / map_w);
            end
            if ($urandom_range(9) == 0)
                r.z = $urandom_range(1) ? 32'h0001_0000 : 32'h0;
            else if ($urandom_range(9) == 0)
                r.z = $urandom_range(1) ? 32'h0001_0001 : $urandom() | 32'h8000_0000;
        end
        else if (pick < 92 && map_w != 0 && map_h != 0
                 && (map_h - 1) * map_w + map_w - 1 >= 65536)
        begin
            // inside the map but past the end of the table
            r.x[31:16] = 16'(map_w - 1);
            r.y[31:16] = 16'(map_h - 1);
        end
        else
            r.z = $urandom();
        if (reads_unwritten(r.x, r.y))
            r.x[31] = 1'b1;
        return r;
    endfunction

    always @(posedge clk)
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            voxel_t e;
            if (pending_voxels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit %0d index %0d",
                             m_axis_tuser[0], m_axis_tdata);
            end
            else
            begin
                e = pending_voxels.pop_front();
                if (m_axis_tuser[0] !== e.hit || m_axis_tdata !== {2'b0, e.idx})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit %0d index %0d, got hit %0d data %0d",
                                 e.hit, e.idx, m_axis_tuser[0], m_axis_tdata);
                end
                hits_seen += e.hit;
            end
        end
    end

    // Watchdog on cycles without any accepted item or register write
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL tiled_volume_voxel_address_unit");
            $finish;
        end
    end

    stim_row_t directed_rows [14];

    initial
    begin
        directed_rows = '{
            // func                  slot      col       row       x              y
            '{tvva_pkg::FUNC_WRITE,  16'h0000, 13'd1,    13'd1,    32'h0,         32'h0,
              32'h0, 0, 0, 0},
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'h0,         32'h0,
              32'h0, 1, 1, 0},
            // top of the cell fractions, z at exactly one
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'h0000_FFFF, 32'h0000_FFFF,
              32'h0001_0000, 1, 1, 0},
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'h0,         32'h0,
              32'h0001_0001, 1, 0, 0},
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'h0,         32'h0,
              32'hFFFF_FFFF, 1, 0, 0},
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'hFFFF_FFFF, 32'h0,
              32'h0, 1, 0, 0},
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'h0001_0000, 32'h0,
              32'h0, 1, 0, 0},
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 1, 0, 0},
            // pixel zero and pixel past the image wrap to 12 bits
            '{tvva_pkg::FUNC_WRITE,  16'hFFFF, 13'd0,    13'h1FFF, 32'h0,         32'h0,
              32'h0, 0, 0, 0},
            '{tvva_pkg::FUNC_WRITE,  16'h0001, 13'd4096, 13'd4096, 32'h0,         32'h0,
              32'h0, 0, 0, 0},
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'h8000_0000, 32'h7FFF_FFFF,
              32'h0, 1, 0, 0},
            '{tvva_pkg::FUNC_WRITE,  16'h0000, 13'd4097, 13'd0,    32'h0,         32'h0,
              32'h0, 0, 0, 0},
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'h0,         32'h0,
              32'h0000_8000, 0, 0, 0},
            '{tvva_pkg::FUNC_LOOKUP, 16'h0000, 13'd0,    13'd0,    32'h0000_8000, 32'h0000_4000,
              32'h0, 0, 0, 0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // Settings from small to oversized, zero sizes and random ones
        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 15 : (phase < 4) ? 57 : 0;
            recv_idle_pct = (phase < 2) ? 57 : (phase < 4) ? 15 : 0;
            s_axis_tvalid <= 1'b0;
            case (phase)
                0: load_config(16, 16, 64, 64, 32, 32, 16);
                1: load_config(256, 256, 4096, 4096, 1024, 1024, 1024);
                2: load_config(0, 0, 0, 0, 0, 0, 0);
                3: load_config(511, 511, 8191, 8191, 2047, 2047, 2047);
                4: load_config(1, 1, 1, 1, 1, 1, 1);
                default: load_config($urandom_range(40, 1), $urandom_range(40, 1),
                                     $urandom_range(300, 1), $urandom_range(300, 1),
                                     $urandom_range(100, 1), $urandom_range(100, 1),
                                     $urandom_range(100, 1));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == PHASE_ITEMS / 2)
                begin
                    // hold the sender until every result is back
                    s_axis_tvalid <= 1'b0;
                    while (pending_voxels.size() != 0)
                        @(posedge clk);
                end
                send_item(random_item(1'b1));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_voxels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d map writes and %0d lookups (%0d hits) over %0d register settings,",
                 writes_sent, lookups_sent, hits_seen, configs_run);
        $display("with idle sender, stalled receiver and back-to-back traffic; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("PASS tiled_volume_voxel_address_unit");
        else
            $display("FAIL tiled_volume_voxel_address_unit");
        $finish;
    end

endmodule
